// ===== design/pli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list package
// Shared widths, operation codes and status codes of the positional list.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 8;
	localparam int COUNT_OUT_W  = 5;

	localparam logic FN_INSERT = 1'b0;
	localparam logic FN_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

endpackage

// ===== design/positional_list_insert_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list with insert and delete
// Ordered list of up to CAPACITY signed values held in a row of cells; every
// cell compares its own index with the request position and shifts in place.
// ----------------------------------------------------------------------------
// Usage:
//   A request (func, value, position) transfers at a rising edge with start
//   high and busy low. busy never rises, so a request may transfer in every
//   cycle. func selects insert (value goes to the 1-based position, later
//   entries move up) or delete (the entry at the position is removed, later
//   entries move down).
//   The request is registered, then decoded and applied to the cell row in
//   the next cycle; the result is registered there. done rises at the edge
//   after the request transfer and pulses for exactly one cycle, carrying
//   status, removed_value (zero unless a delete succeeded) and entry_count;
//   the result transfers at the edge that ends that cycle.
//   Throughput is one request per cycle, set by the in-place shift of the
//   cell row; back-to-back requests see each other's updates in order.
//   The receiver cannot stall: each result is valid for its single cycle.
//   Reset empties the list (count zero) and drops any request in flight;
//   cell contents are not cleared, since only filled cells are ever read.
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
	parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   func,
	input  logic signed [pli_pkg::VALUE_W-1:0]     value,
	input  logic        [pli_pkg::POS_W-1:0]       position,
	output logic                                   done,
	output logic        [1:0]                      status,
	output logic signed [pli_pkg::VALUE_W-1:0]     removed_value,
	output logic        [pli_pkg::COUNT_OUT_W-1:0] entry_count
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = ((CW > pli_pkg::POS_W) ? CW : pli_pkg::POS_W) + 1;

	logic                              valid_s1;
	logic                              func_s1;
	logic signed [pli_pkg::VALUE_W-1:0] value_s1;
	logic [pli_pkg::POS_W-1:0]         position_s1;

	logic [CW-1:0]                     count_q;
	logic signed [pli_pkg::VALUE_W-1:0] entry_q [CAPACITY];

	logic                              done_q;
	pli_pkg::status_t                  status_q;
	logic signed [pli_pkg::VALUE_W-1:0] removed_q;
	logic [pli_pkg::COUNT_OUT_W-1:0]   entry_count_q;

	logic [CMPW-1:0]                   pos_x;
	logic [CMPW-1:0]                   cnt_x;
	logic                              is_insert;
	pli_pkg::status_t                  status_d;
	logic                              do_ins;
	logic                              do_del;
	logic [CW-1:0]                     count_d;
	logic [IW-1:0]                     sel_idx;
	logic signed [pli_pkg::VALUE_W-1:0] removed_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_s1     <= func;
			value_s1    <= value;
			position_s1 <= position;
		end
	end

	assign pos_x     = CMPW'(position_s1);
	assign cnt_x     = CMPW'(count_q);
	assign is_insert = (func_s1 == pli_pkg::FN_INSERT);
	assign sel_idx   = IW'(position_s1 - pli_pkg::POS_W'(1));

	always_comb begin
		if (is_insert) begin
			if (pos_x == '0) begin
				status_d = pli_pkg::ST_BADPOS;
			end else if (cnt_x >= CMPW'(CAPACITY)) begin
				status_d = pli_pkg::ST_FULL;
			end else if (pos_x > cnt_x + CMPW'(1)) begin
				status_d = pli_pkg::ST_BADPOS;
			end else begin
				status_d = pli_pkg::ST_OK;
			end
		end else begin
			if (cnt_x == '0) begin
				status_d = pli_pkg::ST_EMPTY;
			end else if (pos_x == '0 || pos_x > cnt_x) begin
				status_d = pli_pkg::ST_BADPOS;
			end else begin
				status_d = pli_pkg::ST_OK;
			end
		end
	end

	assign do_ins = valid_s1 && is_insert && (status_d == pli_pkg::ST_OK);
	assign do_del = valid_s1 && !is_insert && (status_d == pli_pkg::ST_OK);

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + CW'(1);
		end else if (do_del) begin
			count_d = count_q - CW'(1);
		end
	end

	assign removed_d = do_del ? entry_q[sel_idx] : '0;

	// Each cell picks its next value from its neighbors by its own index.
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [CMPW-1:0]                   kx;
		logic signed [pli_pkg::VALUE_W-1:0] cell_d;
		logic signed [pli_pkg::VALUE_W-1:0] lower;
		logic signed [pli_pkg::VALUE_W-1:0] upper;

		assign kx = CMPW'(k + 1);

		if (k > 0) begin : g_lo
			assign lower = entry_q[k-1];
		end else begin : g_lo0
			assign lower = entry_q[k];
		end

		if (k < CAPACITY - 1) begin : g_hi
			assign upper = entry_q[k+1];
		end else begin : g_hi0
			assign upper = entry_q[k];
		end

		always_comb begin
			cell_d = entry_q[k];
			if (do_ins) begin
				if (kx == pos_x) begin
					cell_d = value_s1;
				end else if (kx > pos_x) begin
					cell_d = lower;
				end
			end else if (do_del) begin
				if (kx >= pos_x) begin
					cell_d = upper;
				end
			end
		end

		always_ff @(posedge clk) begin
			entry_q[k] <= cell_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q      <= status_d;
			removed_q     <= removed_d;
			entry_count_q <= pli_pkg::COUNT_OUT_W'(count_d);
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign entry_count   = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(CAPACITY))
		else $error("list count exceeds capacity");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("registered request produced no result");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not advance count");

	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && status_d != pli_pkg::ST_OK) |=> count_q == $past(count_q))
		else $error("rejected request changed count");

	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && removed_value != '0) |-> status == pli_pkg::ST_OK)
		else $error("removed value on failed request");

endmodule

// ===== tb/pli_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list checker
// Watches the request and reply channels of the positional list. Every
// request transfer is applied to a local copy of the list to work out its
// reply, which joins a FIFO. Every done pulse is compared field by field
// with the oldest reply in that FIFO.
// ----------------------------------------------------------------------------
module pli_list_checker #(
	parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic                                   func,
	input  logic signed [pli_pkg::VALUE_W-1:0]     value,
	input  logic        [pli_pkg::POS_W-1:0]       position,
	input  logic                                   done,
	input  logic        [1:0]                      status,
	input  logic signed [pli_pkg::VALUE_W-1:0]     removed_value,
	input  logic        [pli_pkg::COUNT_OUT_W-1:0] entry_count,
	output int                                     errors,
	output int                                     outstanding,
	output int                                     replies_ok,
	output int                                     replies_badpos,
	output int                                     replies_full,
	output int                                     replies_empty
);

	typedef struct packed {
		pli_pkg::status_t                     st;
		logic signed [pli_pkg::VALUE_W-1:0]   removed;
		logic [pli_pkg::COUNT_OUT_W-1:0]      count;
	} list_reply_t;

	logic signed [pli_pkg::VALUE_W-1:0] list_cells [CAPACITY];
	int                                 list_fill;
	list_reply_t                        replies_due [$];

	initial begin
		errors         = 0;
		outstanding    = 0;
		replies_ok     = 0;
		replies_badpos = 0;
		replies_full   = 0;
		replies_empty  = 0;
	end

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("%0t: mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
		errors++;
	endtask

	function automatic list_reply_t list_edit(input logic fn,
			input logic signed [pli_pkg::VALUE_W-1:0] val,
			input logic [pli_pkg::POS_W-1:0] pos);
		list_reply_t r;
		int          p;
		int          k;
		p         = int'(pos);
		r.st      = pli_pkg::ST_OK;
		r.removed = '0;
		if (fn == pli_pkg::FN_INSERT) begin
			if (p == 0) begin
				r.st = pli_pkg::ST_BADPOS;
			end else if (list_fill >= CAPACITY) begin
				r.st = pli_pkg::ST_FULL;
			end else if (p > list_fill + 1) begin
				r.st = pli_pkg::ST_BADPOS;
			end else begin
				for (k = list_fill; k > p - 1; k--)
					list_cells[k] = list_cells[k - 1];
				list_cells[p - 1] = val;
				list_fill++;
			end
		end else begin
			if (list_fill == 0) begin
				r.st = pli_pkg::ST_EMPTY;
			end else if (p == 0 || p > list_fill) begin
				r.st = pli_pkg::ST_BADPOS;
			end else begin
				r.removed = list_cells[p - 1];
				for (k = p - 1; k + 1 < list_fill; k++)
					list_cells[k] = list_cells[k + 1];
				list_fill--;
			end
		end
		r.count = pli_pkg::COUNT_OUT_W'(list_fill);
		return r;
	endfunction

	task automatic compare_reply();
		list_reply_t want;
		if (replies_due.size() == 0) begin
			$display("%0t: reply with no request pending", $realtime);
			errors++;
		end else begin
			want = replies_due.pop_front();
			case (want.st)
				pli_pkg::ST_OK:     replies_ok++;
				pli_pkg::ST_BADPOS: replies_badpos++;
				pli_pkg::ST_FULL:   replies_full++;
				default:            replies_empty++;
			endcase
			if (status !== want.st)
				report_mismatch("status", longint'(status), longint'(want.st));
			if (removed_value !== want.removed)
				report_mismatch("removed_value", longint'(removed_value), longint'(want.removed));
			if (entry_count !== want.count)
				report_mismatch("entry_count", longint'(entry_count), longint'(want.count));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_fill = 0;
			replies_due.delete();
			outstanding = 0;
		end else begin
			if (done === 1'b1)
				compare_reply();
			if (start && !busy)
				replies_due.push_back(list_edit(func, value, position));
			outstanding = replies_due.size();
		end
	end

endmodule

// ===== tb/tb_positional_list_insert_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list testbench
// Drives insert and delete requests into the positional list: a directed
// walk through empty, partly filled and full lists with the value and
// position extremes, then phases of random requests that fill, drain or mix,
// with random or no gaps between requests. The checker beside the block
// predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_positional_list_insert_delete;

	localparam int CAPACITY     = pli_pkg::CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 750;

	logic                                     clk      = 1'b0;
	logic                                     arst_n   = 1'b0;
	logic                                     start    = 1'b0;
	logic                                     func     = pli_pkg::FN_INSERT;
	logic signed [pli_pkg::VALUE_W-1:0]       value    = '0;
	logic        [pli_pkg::POS_W-1:0]         position = '0;
	logic                                     busy;
	logic                                     done;
	logic        [1:0]                        status;
	logic signed [pli_pkg::VALUE_W-1:0]       removed_value;
	logic        [pli_pkg::COUNT_OUT_W-1:0]   entry_count;
	int                                       errors;
	int                                       outstanding;
	int                                       replies_ok;
	int                                       replies_badpos;
	int                                       replies_full;
	int                                       replies_empty;

	int fill_est    = 0;
	int n_inserts   = 0;
	int n_deletes   = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	positional_list_insert_delete #(.CAPACITY(CAPACITY)) dut (.*);

	pli_list_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

	task automatic send_request(input logic fn, input logic signed [pli_pkg::VALUE_W-1:0] val,
			input logic [pli_pkg::POS_W-1:0] pos, input int gap);
		bit taken;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		func     <= fn;
		value    <= val;
		position <= pos;
		forever begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
			if (taken)
				break;
		end
		if (fn == pli_pkg::FN_INSERT) begin
			n_inserts++;
			if (pos != 0 && fill_est < CAPACITY && pos <= fill_est + 1)
				fill_est++;
		end else begin
			n_deletes++;
			if (pos != 0 && pos <= fill_est)
				fill_est--;
		end
	endtask

	function automatic logic [pli_pkg::POS_W-1:0] pick_position(input logic fn);
		int r;
		int hi;
		r  = $urandom_range(0, 99);
		hi = (fn == pli_pkg::FN_INSERT) ? fill_est + 1 : fill_est;
		if (hi == 0)
			hi = 1;
		if (r < 10)
			return pli_pkg::POS_W'(1);
		else if (r < 20)
			return pli_pkg::POS_W'(hi);
		else if (r < 78)
			return pli_pkg::POS_W'($urandom_range(1, hi));
		else if (r < 84)
			return pli_pkg::POS_W'(0);
		else if (r < 90)
			return pli_pkg::POS_W'(hi + 1);
		else
			return pli_pkg::POS_W'($urandom_range(0, 255));
	endfunction

	function automatic logic signed [pli_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return 32'sd0;
			3:       return -32'sd1;
			default: return $signed($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int  sent;
		int  i;
		int  mode;
		int  phase_len;
		bit  no_gaps;
		logic fn;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(pli_pkg::FN_DELETE, 32'sd5, 8'd1, 0);
		send_request(pli_pkg::FN_DELETE, -32'sd5, 8'd0, 1);
		send_request(pli_pkg::FN_INSERT, 32'sd9, 8'd0, 0);
		send_request(pli_pkg::FN_INSERT, 32'sd9, 8'd2, 2);
		send_request(pli_pkg::FN_INSERT, 32'sh7fffffff, 8'd1, 0);
		send_request(pli_pkg::FN_INSERT, 32'sh80000000, 8'd1, 0);
		send_request(pli_pkg::FN_INSERT, -32'sd1, 8'd3, 3);
		send_request(pli_pkg::FN_INSERT, 32'sd0, 8'd2, 0);
		while (fill_est < CAPACITY)
			send_request(pli_pkg::FN_INSERT, $signed($urandom),
				pli_pkg::POS_W'($urandom_range(1, fill_est + 1)), $urandom_range(0, 1));
		send_request(pli_pkg::FN_INSERT, 32'sd7, 8'd0, 0);
		send_request(pli_pkg::FN_INSERT, 32'sd7, 8'd1, 0);
		send_request(pli_pkg::FN_INSERT, 32'sd7, 8'd255, 0);
		send_request(pli_pkg::FN_DELETE, 32'sd0, 8'd8, 0);
		send_request(pli_pkg::FN_DELETE, 32'sd0, pli_pkg::POS_W'(fill_est), 1);
		send_request(pli_pkg::FN_DELETE, 32'sd0, 8'd1, 0);
		send_request(pli_pkg::FN_DELETE, 32'sd0, 8'd0, 0);
		send_request(pli_pkg::FN_DELETE, 32'sd0, 8'd255, 0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode      = $urandom_range(0, 2);
			phase_len = $urandom_range(8, 40);
			no_gaps   = ($urandom_range(0, 3) == 0);
			for (i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
				case (mode)
					0:       fn = ($urandom_range(0, 99) < 15) ? pli_pkg::FN_DELETE
							: pli_pkg::FN_INSERT;
					1:       fn = ($urandom_range(0, 99) < 85) ? pli_pkg::FN_DELETE
							: pli_pkg::FN_INSERT;
					default: fn = $urandom_range(0, 1) ? pli_pkg::FN_DELETE
							: pli_pkg::FN_INSERT;
				endcase
				send_request(fn, pick_value(), pick_position(fn),
					no_gaps ? 0 : $urandom_range(0, 9));
				sent++;
			end
		end
		start <= 1'b0;

		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		@(negedge clk);

		$display("requests sent: %0d inserts, %0d deletes across fill, drain and mixed phases",
			n_inserts, n_deletes);
		$display("replies: %0d ok, %0d bad position, %0d list full, %0d list empty",
			replies_ok, replies_badpos, replies_full, replies_empty);
		if (errors == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : watchdog
		#200000;
		$display("simulation failed");
		$finish;
	end

endmodule
